FILE: rtl/button_debounce_long_press_macros.svh
// Assertion macros for the button debouncer RTL.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef BUTTON_DEBOUNCE_LONG_PRESS_MACROS_SVH
`define BUTTON_DEBOUNCE_LONG_PRESS_MACROS_SVH

// Same-cycle implication.
`define BDLP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bdlp assertion failed");

// Next-cycle implication.
`define BDLP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bdlp assertion failed");

`endif

FILE: rtl/bdlp_pkg.sv
// Package for the button debouncer with long-press detection.
// Types and constants shared by the RTL; no dependencies.
`timescale 1ns / 1ps

package bdlp_pkg;

  localparam int NUM_BUTTONS_DEF = 3;
  localparam int LEVELS_W        = 3;
  localparam int IDX_W           = 4;
  localparam int HOLD_W          = 16;
  localparam int OP_W            = 2;
  localparam int IN_DATA_W       = 8;
  localparam int OUT_DATA_W      = 8;
  localparam int CFG_ADDR_W      = 3;
  localparam int CFG_DATA_W      = 32;

  localparam logic [HOLD_W-1:0] HOLD_RESET = 16'd100;

  localparam logic [CFG_ADDR_W-1:0] REG_HOLD_TICKS = 3'd0;

  typedef enum logic [OP_W-1:0] {
    OP_TICK     = 2'd0,
    OP_RD_PRESS = 2'd1,
    OP_RD_LONG  = 2'd2
  } op_t;

endpackage

FILE: rtl/button_debounce_long_press.sv
// Registered: a result appears on out_* in the cycle after its transaction is accepted.
// Throughput: one transaction per cycle; in_tready drops only while a result
// waits in the output register and out_tready is low.
// Reset (rst_n, synchronous, active low): all buttons released, flags clear,
// hold counters and hold_ticks at 100, output register empty.
// Depends on bdlp_pkg and button_debounce_long_press_macros.svh.
`timescale 1ns / 1ps

module button_debounce_long_press #(
  parameter int NUM_BUTTONS = bdlp_pkg::NUM_BUTTONS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [bdlp_pkg::IN_DATA_W-1:0]   in_tdata,    // levels[2:0], button_index[6:3], 0
  input  logic [bdlp_pkg::OP_W-1:0]        in_tuser,    // op[1:0]
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [bdlp_pkg::OUT_DATA_W-1:0]  out_tdata,   // answer[0], index_error[1], 0
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [bdlp_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [bdlp_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [bdlp_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                             cfg_pready
);
  import bdlp_pkg::*;
  `include "button_debounce_long_press_macros.svh"

  logic [HOLD_W-1:0]      hold_ticks_r;
  logic [NUM_BUTTONS-1:0] newest_r, newest_nxt;
  logic [NUM_BUTTONS-1:0] stable_r, stable_nxt;
  logic [NUM_BUTTONS-1:0] pend_r, pend_nxt;
  logic [NUM_BUTTONS-1:0] long_r, long_nxt;
  logic [HOLD_W-1:0]      cnt_r   [NUM_BUTTONS];
  logic [HOLD_W-1:0]      cnt_nxt [NUM_BUTTONS];
  logic                   out_valid_r;
  logic                   answer_r, answer_nxt;
  logic                   err_r, err_nxt;

  logic                   in_fire;
  op_t                    op;
  logic [LEVELS_W-1:0]    in_levels;
  logic [IDX_W-1:0]       in_idx;
  logic                   is_query;
  logic                   idx_bad;
  logic [NUM_BUTTONS-1:0] raw;
  logic [NUM_BUTTONS-1:0] query_hit;
  logic                   cfg_wr;

  assign in_fire   = in_tvalid && in_tready;
  assign in_tready = !out_valid_r || out_tready;
  assign op        = op_t'(in_tuser);
  assign in_levels = in_tdata[LEVELS_W-1:0];
  assign in_idx    = in_tdata[LEVELS_W+IDX_W-1:LEVELS_W];
  assign is_query  = (op == OP_RD_PRESS) || (op == OP_RD_LONG);
  assign idx_bad   = ({1'b0, in_idx} >= (IDX_W+1)'(NUM_BUTTONS));

  // Buttons past the levels field see 0 (pressed).
  for (genvar g = 0; g < NUM_BUTTONS; g++) begin : g_raw
    if (g < LEVELS_W) begin : g_in
      assign raw[g] = in_levels[g];
    end else begin : g_zero
      assign raw[g] = 1'b0;
    end
  end

  always_comb begin
    for (int b = 0; b < NUM_BUTTONS; b++) begin
      query_hit[b] = is_query && (in_idx == IDX_W'(b));
    end
  end

  // Per-button debounce and hold countdown on ticks; press and long-press reads return and clear a flag.
  always_comb begin
    logic [HOLD_W-1:0] dec;
    dec        = '0;
    newest_nxt = newest_r;
    stable_nxt = stable_r;
    pend_nxt   = pend_r;
    long_nxt   = long_r;
    for (int b = 0; b < NUM_BUTTONS; b++) begin
      cnt_nxt[b] = cnt_r[b];
    end
    answer_nxt = 1'b0;
    err_nxt    = 1'b0;
    case (op)
      OP_TICK: begin
        newest_nxt = raw;
        for (int b = 0; b < NUM_BUTTONS; b++) begin
          dec = cnt_r[b] - 1'b1;
          if (raw[b] == newest_r[b]) begin
            if (newest_r[b] != stable_r[b]) begin
              stable_nxt[b] = newest_r[b];
              if (!newest_r[b]) begin
                pend_nxt[b] = 1'b1;
                cnt_nxt[b]  = hold_ticks_r;
              end
            end else if (dec == '0) begin
              cnt_nxt[b] = hold_ticks_r;
              if (!stable_r[b]) begin
                pend_nxt[b] = 1'b0;
                long_nxt[b] = 1'b1;
              end else begin
                long_nxt[b] = 1'b0;
              end
            end else begin
              cnt_nxt[b] = dec;
            end
          end
        end
      end
      OP_RD_PRESS: begin
        err_nxt    = idx_bad;
        answer_nxt = |(query_hit & pend_r);
        pend_nxt   = pend_r & ~query_hit;
      end
      OP_RD_LONG: begin
        err_nxt    = idx_bad;
        answer_nxt = |(query_hit & long_r);
        long_nxt   = long_r & ~query_hit;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      newest_r <= '1;
      stable_r <= '1;
      pend_r   <= '0;
      long_r   <= '0;
      for (int b = 0; b < NUM_BUTTONS; b++) begin
        cnt_r[b] <= HOLD_RESET;
      end
    end else if (in_fire) begin
      newest_r <= newest_nxt;
      stable_r <= stable_nxt;
      pend_r   <= pend_nxt;
      long_r   <= long_nxt;
      for (int b = 0; b < NUM_BUTTONS; b++) begin
        cnt_r[b] <= cnt_nxt[b];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      answer_r <= answer_nxt;
      err_r    <= err_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W-2){1'b0}}, err_r, answer_r};

  // Config port
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_ticks_r <= HOLD_RESET;
    end else if (cfg_wr && (cfg_paddr[CFG_ADDR_W-1] == REG_HOLD_TICKS[CFG_ADDR_W-1])) begin
      hold_ticks_r <= cfg_pwdata[HOLD_W-1:0];
    end
  end

  assign cfg_prdata = (cfg_paddr[CFG_ADDR_W-1] == REG_HOLD_TICKS[CFG_ADDR_W-1]) ?
                      {{(CFG_DATA_W-HOLD_W){1'b0}}, hold_ticks_r} : '0;

  `BDLP_ASSERT_NEXT(a_tick_result_zero, in_fire && (op == OP_TICK),
                    out_tvalid && (out_tdata == '0))
  `BDLP_ASSERT_NEXT(a_bad_index_flagged, in_fire && is_query && idx_bad,
                    out_tvalid && out_tdata[1] && !out_tdata[0])
  `BDLP_ASSERT_NEXT(a_press_read_clears, in_fire && (op == OP_RD_PRESS),
                    ($past(query_hit) & pend_r) == '0)
  `BDLP_ASSERT_NEXT(a_stable_only_on_tick, !(in_fire && (op == OP_TICK)),
                    $stable(stable_r))

endmodule

FILE: sim/button_debounce_long_press_tb.sv
// Testbench for button_debounce_long_press: directed and random tick/query traffic,
// each result checked against a cycle-free predictor of the debounce state.
// Depends on bdlp_pkg and the button_debounce_long_press RTL.
`timescale 1ns / 1ps

module button_debounce_long_press_tb;
  import bdlp_pkg::*;

  localparam int NUM_BUTTONS = NUM_BUTTONS_DEF;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic answer;
    logic index_error;
  } answer_t;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata;     // levels[2:0], button_index[6:3], 0
  logic [OP_W-1:0] in_tuser;          // op[1:0]
  logic out_tvalid;
  logic out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;   // answer[0], index_error[1], 0
  logic cfg_psel;
  logic cfg_penable;
  logic cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic cfg_pready;

  // predicted debounce state
  logic [HOLD_W-1:0] hold_ticks_cfg;
  bit newest_lvl [NUM_BUTTONS];
  bit older_lvl [NUM_BUTTONS];
  bit stable_lvl [NUM_BUTTONS];
  bit press_pending [NUM_BUTTONS];
  bit long_press [NUM_BUTTONS];
  logic [HOLD_W-1:0] hold_left [NUM_BUTTONS];

  answer_t answer_q[$];
  answer_t exp_answer;
  answer_t got_answer;
  int mismatches;
  int sender_idle_pct;
  int stall_pct;

  button_debounce_long_press dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .cfg_psel(cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr),
    .cfg_pwdata(cfg_pwdata),
    .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  // Update predicted state for one accepted transaction and queue its result.
  function automatic void predict_debounce(input logic [OP_W-1:0] op,
                                           input logic [LEVELS_W-1:0] levels,
                                           input logic [IDX_W-1:0] idx);
    answer_t r;
    r = '0;
    if (op == OP_TICK) begin
      for (int b = 0; b < NUM_BUTTONS; b++) begin
        older_lvl[b] = newest_lvl[b];
        newest_lvl[b] = levels[b];
        if (newest_lvl[b] == older_lvl[b]) begin
          if (older_lvl[b] != stable_lvl[b]) begin
            stable_lvl[b] = older_lvl[b];
            if (!stable_lvl[b]) begin
              press_pending[b] = 1'b1;
              hold_left[b] = hold_ticks_cfg;
            end
          end else begin
            hold_left[b] = hold_left[b] - 1'b1;
            if (hold_left[b] == '0) begin
              hold_left[b] = hold_ticks_cfg;
              if (!stable_lvl[b]) begin
                press_pending[b] = 1'b0;
                long_press[b] = 1'b1;
              end else begin
                long_press[b] = 1'b0;
              end
            end
          end
        end
      end
    end else if (op == OP_RD_PRESS || op == OP_RD_LONG) begin
      if (idx >= NUM_BUTTONS) begin
        r.index_error = 1'b1;
      end else if (op == OP_RD_PRESS) begin
        r.answer = press_pending[idx];
        press_pending[idx] = 1'b0;
      end else begin
        r.answer = long_press[idx];
        long_press[idx] = 1'b0;
      end
    end
    answer_q.push_back(r);
  endfunction

  task automatic send_item(input logic [OP_W-1:0] op, input logic [LEVELS_W-1:0] levels,
                           input logic [IDX_W-1:0] idx);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {1'b0, idx, levels};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_debounce(op, levels, idx);
  endtask

  task automatic wait_results_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (answer_q.size() != 0);
  endtask

  task automatic write_hold_ticks(input logic [HOLD_W-1:0] value);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= REG_HOLD_TICKS;
    cfg_pwdata <= {{(CFG_DATA_W-HOLD_W){1'b0}}, value};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    hold_ticks_cfg = value;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  task automatic start_phase(input logic [HOLD_W-1:0] hold, input int idle, input int stall);
    wait_results_drained();
    sender_idle_pct = idle;
    stall_pct = stall;
    write_hold_ticks(hold);
  endtask

  // Buttons held for random stretches with some contact bounce, mixed with queries.
  task automatic run_button_traffic(input int n_items, input bit pause_midway);
    logic [LEVELS_W-1:0] held;
    logic [LEVELS_W-1:0] bounce;
    int roll;
    held = '1;
    for (int i = 0; i < n_items; i++) begin
      if (pause_midway && i == n_items / 2) wait_results_drained();
      roll = $urandom_range(99);
      if (roll < 68) begin
        bounce = '0;
        for (int b = 0; b < LEVELS_W; b++) begin
          if ($urandom_range(99) < 8) held[b] = ~held[b];
          if ($urandom_range(99) < 10) bounce[b] = 1'b1;
        end
        send_item(OP_TICK, held ^ bounce, IDX_W'($urandom_range(15)));
      end else if (roll < 94) begin
        send_item($urandom_range(1) ? OP_RD_LONG : OP_RD_PRESS, LEVELS_W'($urandom),
                  ($urandom_range(9) == 0) ? IDX_W'($urandom_range(15, NUM_BUTTONS))
                                           : IDX_W'($urandom_range(NUM_BUTTONS - 1)));
      end else begin
        send_item($urandom_range(1) ? OP_UNUSED : OP_TICK, LEVELS_W'($urandom),
                  IDX_W'($urandom));
      end
    end
  endtask

  task automatic test_reset_state();
    start_phase(HOLD_RESET, 0, 0);
    send_item(OP_RD_PRESS, 3'b000, 4'd0);
    send_item(OP_RD_LONG, 3'b111, 4'd2);
    send_item(OP_RD_PRESS, 3'b010, 4'd3);
    send_item(OP_RD_LONG, 3'b101, 4'd15);
    send_item(OP_RD_PRESS, 3'b000, 4'd8);
    send_item(OP_RD_LONG, 3'b000, 4'd4);
    send_item(OP_UNUSED, 3'b111, 4'd1);
  endtask

  task automatic test_press_and_long_press();
    start_phase(16'd2, 0, 0);
    send_item(OP_TICK, 3'b110, 4'd0);
    send_item(OP_TICK, 3'b110, 4'd0);
    send_item(OP_RD_PRESS, 3'b000, 4'd0);
    send_item(OP_RD_PRESS, 3'b000, 4'd0);
    send_item(OP_TICK, 3'b110, 4'd0);
    send_item(OP_TICK, 3'b110, 4'd0);
    send_item(OP_RD_LONG, 3'b000, 4'd0);
    send_item(OP_RD_LONG, 3'b000, 4'd0);
    // bounce on button 0 is filtered; buttons 1 and 2 settle pressed
    send_item(OP_TICK, 3'b001, 4'd0);
    send_item(OP_TICK, 3'b000, 4'd0);
    send_item(OP_TICK, 3'b000, 4'd0);
    send_item(OP_TICK, 3'b000, 4'd0);
    send_item(OP_RD_PRESS, 3'b000, 4'd1);
    send_item(OP_RD_LONG, 3'b000, 4'd2);
    // release without reload, then long flag cleared on countdown
    send_item(OP_TICK, 3'b111, 4'd0);
    send_item(OP_TICK, 3'b111, 4'd0);
    send_item(OP_TICK, 3'b111, 4'd0);
    send_item(OP_TICK, 3'b111, 4'd0);
    send_item(OP_RD_LONG, 3'b000, 4'd0);
  endtask

  task automatic test_fast_hold();
    start_phase(16'd1, 0, 0);
    run_button_traffic(90, 1'b0);
  endtask

  task automatic test_sender_gaps();
    start_phase(16'd4, 64, 0);
    run_button_traffic(90, 1'b1);
  endtask

  task automatic test_receiver_stalls();
    start_phase(16'hffff, 0, 64);
    run_button_traffic(80, 1'b0);
  endtask

  task automatic test_zero_hold();
    start_phase(16'd0, 35, 35);
    run_button_traffic(60, 1'b0);
  endtask

  task automatic test_mixed_idle();
    start_phase(16'd6, 35, 35);
    run_button_traffic(110, 1'b0);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got_answer.answer = out_tdata[0];
      got_answer.index_error = out_tdata[1];
      if (answer_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: answer=%0b index_error=%0b",
                   got_answer.answer, got_answer.index_error);
      end else begin
        exp_answer = answer_q.pop_front();
        if (got_answer.answer !== exp_answer.answer ||
            got_answer.index_error !== exp_answer.index_error) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected answer=%0b index_error=%0b, got answer=%0b index_error=%0b",
                     exp_answer.answer, exp_answer.index_error,
                     got_answer.answer, got_answer.index_error);
        end
      end
    end
  end

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = OP_TICK;
    out_tready = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    mismatches = 0;
    sender_idle_pct = 0;
    stall_pct = 0;
    hold_ticks_cfg = HOLD_RESET;
    for (int b = 0; b < NUM_BUTTONS; b++) begin
      newest_lvl[b] = 1'b1;
      older_lvl[b] = 1'b1;
      stable_lvl[b] = 1'b1;
      press_pending[b] = 1'b0;
      long_press[b] = 1'b0;
      hold_left[b] = HOLD_RESET;
    end
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_state();
    test_press_and_long_press();
    test_fast_hold();
    test_sender_gaps();
    test_receiver_stalls();
    test_zero_hold();
    test_mixed_idle();

    wait_results_drained();
    repeat (4) @(posedge clk);
    if (mismatches == 0 && answer_q.size() == 0) begin
      $display("PASS button_debounce_long_press");
    end else begin
      $display("FAIL button_debounce_long_press");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAIL button_debounce_long_press");
    $finish;
  end

endmodule
